[sv/tcfe_pkg.sv]
// Shared types, constants and the microcode program of the trainer channel frame encoder.
package tcfe_pkg;

   localparam int CHANNEL_COUNT_DEFAULT = 8;

   localparam int VALUE_W = 12;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 4;
   localparam int CSR_INDEX_W = 4;

   localparam logic [VALUE_W-1:0] RESET_CENTER = 12'd1500;
   localparam logic [BYTE_W-1:0]  RESET_FLAG   = 8'd126;
   localparam logic [BYTE_W-1:0]  RESET_ESCAPE = 8'd125;
   localparam logic [BYTE_W-1:0]  RESET_MASK   = 8'd32;
   localparam logic [BYTE_W-1:0]  FRAME_TYPE   = 8'h80;

   localparam logic [CSR_INDEX_W-1:0] REG_CENTER = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLAG   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MASK   = 4'd3;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_HEAD = 3'd0;
   localparam step_type STEP_TYPE = 3'd1;
   localparam step_type STEP_B0   = 3'd2;
   localparam step_type STEP_B1   = 3'd3;
   localparam step_type STEP_B2   = 3'd4;
   localparam step_type STEP_CSUM = 3'd5;
   localparam step_type STEP_TAIL = 3'd6;

   typedef enum logic [1:0] {
      SRC_FLAG = 2'd0,
      SRC_TYPE = 2'd1,
      SRC_DATA = 2'd2,
      SRC_CSUM = 2'd3
   } byte_src_type;

   typedef enum logic [1:0] {
      SEL_B0 = 2'd0,
      SEL_B1 = 2'd1,
      SEL_B2 = 2'd2
   } data_sel_type;

   typedef struct packed {
      byte_src_type src;
      data_sel_type sel;
      logic         csum_clr;
      logic         pair_clr;
      logic         fetch;
      logic         pair_adv;
      logic         jump_more;
      step_type     target;
      logic         last;
      logic         done;
   } ucode_word_type;

   typedef struct packed {
      logic           active;
      ucode_word_type cw;
   } seq_ctrl_type;

   typedef struct packed {
      logic hold;
      logic pair_last;
   } dp_status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] center;
      logic [BYTE_W-1:0]  flag;
      logic [BYTE_W-1:0]  escape;
      logic [BYTE_W-1:0]  mask;
   } cfg_type;

   // The frame program: one control word per step.
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      w        = '0;
      w.src    = SRC_FLAG;
      w.sel    = SEL_B0;
      w.target = STEP_HEAD;
      unique case (step)
         STEP_HEAD: begin
            w.src      = SRC_FLAG;
            w.csum_clr = 1'b1;
            w.pair_clr = 1'b1;
         end
         STEP_TYPE: begin
            w.src   = SRC_TYPE;
            w.fetch = 1'b1;
         end
         STEP_B0: begin
            w.src = SRC_DATA;
            w.sel = SEL_B0;
         end
         STEP_B1: begin
            w.src = SRC_DATA;
            w.sel = SEL_B1;
         end
         STEP_B2: begin
            w.src       = SRC_DATA;
            w.sel       = SEL_B2;
            w.fetch     = 1'b1;
            w.pair_adv  = 1'b1;
            w.jump_more = 1'b1;
            w.target    = STEP_B0;
         end
         STEP_CSUM: begin
            w.src = SRC_CSUM;
         end
         STEP_TAIL: begin
            w.src  = SRC_FLAG;
            w.last = 1'b1;
            w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

[sv/trainer_channel_frame_encoder.sv]
// Top level of the trainer channel frame encoder: ports, control registers and wiring.
//
// The block keeps CHANNEL_COUNT 12-bit channel values and turns them into byte-stuffed
// frames. A request is taken on a rising edge with start high and busy low. A set
// request (req_type 0) writes one channel as it is taken and raises no busy; a
// value of zero stores the current center value and an index at or above CHANNEL_COUNT
// is dropped. A send request (req_type 1) raises busy for the frame: a flag byte, the
// type byte 0x80, three bytes per channel pair, the XOR checksum and a closing flag
// byte marked by rsp_last_byte. The microcode program has a head step, a type step,
// three data steps per channel pair, a checksum step and a tail step. Each step emits
// one byte, but a data step that needs escaping is held so that it emits the escape
// byte first and then the masked data byte. Each byte appears on rsp_frame_byte for
// exactly one cycle with rsp_strobe high, in the cycle after the step that made it, as
// the byte is registered, and a frame's first beat comes from its head step; the
// receiver cannot stall, so it must take every beat as it comes. A new
// request may be taken the cycle busy falls, while the closing beat is still on the
// result ports. The control registers are written through the csr_ channel, which is
// always ready; writes to an unknown index are ignored, and registers should only
// change while the block is idle.
module trainer_channel_frame_encoder #(
   parameter int CHANNEL_COUNT = tcfe_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic [tcfe_pkg::INDEX_W-1:0]        req_channel_index,
   input  logic [tcfe_pkg::VALUE_W-1:0]        req_channel_value,

   output logic                                rsp_strobe,
   output logic [tcfe_pkg::BYTE_W-1:0]         rsp_frame_byte,
   output logic                                rsp_last_byte,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcfe_pkg::VALUE_W-1:0]        csr_wdata
);

   tcfe_pkg::cfg_type       cfg_ff;
   tcfe_pkg::seq_ctrl_type  ctrl;
   tcfe_pkg::dp_status_type status;
   logic                    accept;
   logic                    set_en;
   logic                    frame_go;

   // A beat on the request channel is taken only while no frame is running.
   assign accept   = start && !busy;
   assign set_en   = accept && !req_type;
   assign frame_go = start && req_type;

   // The control register file always takes a write in the cycle it is offered.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center <= tcfe_pkg::RESET_CENTER;
         cfg_ff.flag   <= tcfe_pkg::RESET_FLAG;
         cfg_ff.escape <= tcfe_pkg::RESET_ESCAPE;
         cfg_ff.mask   <= tcfe_pkg::RESET_MASK;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcfe_pkg::REG_CENTER: cfg_ff.center <= csr_wdata;
            tcfe_pkg::REG_FLAG:   cfg_ff.flag   <= csr_wdata[tcfe_pkg::BYTE_W-1:0];
            tcfe_pkg::REG_ESCAPE: cfg_ff.escape <= csr_wdata[tcfe_pkg::BYTE_W-1:0];
            tcfe_pkg::REG_MASK:   cfg_ff.mask   <= csr_wdata[tcfe_pkg::BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The sequencer steps through the frame program and stalls on escape holds.
   tcfe_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .frame_go (frame_go),
      .status   (status),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   // The datapath stores the channels and builds each byte under microcode control.
   tcfe_dp #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .set_en     (set_en),
      .set_index  (req_channel_index),
      .set_value  (req_channel_value),
      .ctrl       (ctrl),
      .status     (status),
      .out_strobe (rsp_strobe),
      .out_byte   (rsp_frame_byte),
      .out_last   (rsp_last_byte)
   );

`ifndef SYNTHESIS
   // The closing beat is always a real beat.
   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_byte |-> rsp_strobe)
      else $error("last byte flagged without a strobe");
   // A frame's closing beat is never followed directly by another beat.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_last_byte |=> !rsp_strobe)
      else $error("beat directly after the closing byte");
   // An accepted send request starts the sequencer.
   a_send_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type) |=> busy)
      else $error("send request did not start a frame");
   // A set request never starts a frame.
   a_set_stays_idle: assert property (@(posedge clock) disable iff (reset)
      set_en |=> !busy)
      else $error("set request raised busy");
`endif

endmodule

[sv/tcfe_seq.sv]
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module tcfe_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   frame_go,
   input  tcfe_pkg::dp_status_type status,
   output tcfe_pkg::seq_ctrl_type  ctrl,
   output logic                   busy
);

   tcfe_pkg::step_type step_ff, step_in;
   logic               busy_ff, busy_in;
   tcfe_pkg::ucode_word_type cw;

   assign cw = tcfe_pkg::ucode_rom(step_ff);

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      priority if (frame_go && !busy_ff) begin
         busy_in = 1'b1;
         step_in = tcfe_pkg::STEP_HEAD;
      end else if (busy_ff && !status.hold) begin
         priority if (cw.done) begin
            busy_in = 1'b0;
         end else if (cw.jump_more && !status.pair_last) begin
            step_in = cw.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= tcfe_pkg::STEP_HEAD;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl.active = busy_ff;
   assign ctrl.cw     = cw;
   assign busy        = busy_ff;

`ifndef SYNTHESIS
   // A held step never moves the counter.
   a_hold_keeps_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && status.hold) |=> (step_ff == $past(step_ff)))
      else $error("step advanced during an escape hold");
   // The program never runs past its last step.
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= tcfe_pkg::STEP_TAIL))
      else $error("step counter left the program");
   // Two holds in a row would mean the escape flag failed.
   a_single_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && status.hold) |=> !status.hold)
      else $error("escape hold lasted more than one cycle");
`endif

endmodule

[sv/tcfe_dp.sv]
// Datapath: channel store banks, pair fetch, escaping, checksum and result register.
module tcfe_dp #(
   parameter int CHANNEL_COUNT = tcfe_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcfe_pkg::cfg_type                 cfg,
   input  logic                              set_en,
   input  logic [tcfe_pkg::INDEX_W-1:0]      set_index,
   input  logic [tcfe_pkg::VALUE_W-1:0]      set_value,
   input  tcfe_pkg::seq_ctrl_type            ctrl,
   output tcfe_pkg::dp_status_type           status,
   output logic                              out_strobe,
   output logic [tcfe_pkg::BYTE_W-1:0]       out_byte,
   output logic                              out_last
);

   localparam int PAIR_COUNT = (CHANNEL_COUNT + 1) / 2;
   localparam int ODD_DEPTH  = CHANNEL_COUNT / 2;
   localparam int EVEN_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
   localparam int ODD_W      = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;

   localparam int VW = tcfe_pkg::VALUE_W;
   localparam int BW = tcfe_pkg::BYTE_W;

   // Even channels live in one bank, odd channels in the other, one row per pair.
   logic [VW-1:0]         mem_even_ff [PAIR_COUNT];
   logic [VW-1:0]         mem_odd_ff  [ODD_DEPTH];
   logic [PAIR_COUNT-1:0] vld_even_ff;
   logic [ODD_DEPTH-1:0]  vld_odd_ff;

   logic [VW-1:0] rd_even_ff, rd_odd_ff;
   logic          rd_even_vld_ff, rd_odd_vld_ff, rd_odd_rng_ff;

   logic [EVEN_W-1:0] pair_ff, pair_in;
   logic [BW-1:0]     csum_ff, csum_in;
   logic              esc_pend_ff;
   logic              strobe_ff;
   logic [BW-1:0]     byte_ff, byte_in;
   logic              last_ff;

   logic              set_rng;
   logic [EVEN_W-1:0] wr_row;
   logic [VW-1:0]     wr_val;
   logic              pair_last;
   logic [EVEN_W-1:0] rd_addr;
   logic              fetch_en;
   logic [VW-1:0]     ch_a, ch_b;
   logic [BW-1:0]     raw;
   logic              esc_need;
   logic              go;
   tcfe_pkg::ucode_word_type cw;

   assign cw = ctrl.cw;

   assign set_rng = ({1'b0, set_index} < (tcfe_pkg::INDEX_W + 1)'(CHANNEL_COUNT));
   assign wr_row  = EVEN_W'(set_index[tcfe_pkg::INDEX_W-1:1]);
   assign wr_val  = (set_value == '0) ? cfg.center : set_value;

   assign pair_last = (pair_ff == EVEN_W'(PAIR_COUNT - 1));
   assign rd_addr   = cw.pair_adv ? (pair_ff + 1'b1) : pair_ff;
   assign go        = ctrl.active && !esc_need;
   assign fetch_en  = ctrl.active && cw.fetch && (!cw.pair_adv || (go && !pair_last));

   always_ff @(posedge clock) begin
      if (set_en && set_rng && !set_index[0]) begin
         mem_even_ff[wr_row] <= wr_val;
      end
      if (set_en && set_rng && set_index[0]) begin
         mem_odd_ff[ODD_W'(wr_row)] <= wr_val;
      end
      if (fetch_en) begin
         rd_even_ff     <= mem_even_ff[rd_addr];
         rd_even_vld_ff <= vld_even_ff[rd_addr];
         rd_odd_ff      <= mem_odd_ff[ODD_W'(rd_addr)];
         rd_odd_vld_ff  <= vld_odd_ff[ODD_W'(rd_addr)];
         rd_odd_rng_ff  <= ({1'b0, rd_addr} < (EVEN_W + 1)'(ODD_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_even_ff <= '0;
         vld_odd_ff  <= '0;
      end else begin
         if (set_en && set_rng && !set_index[0]) begin
            vld_even_ff[wr_row] <= 1'b1;
         end
         if (set_en && set_rng && set_index[0]) begin
            vld_odd_ff[ODD_W'(wr_row)] <= 1'b1;
         end
      end
   end

   // A row never written reads as the reset center value.
   assign ch_a = rd_even_vld_ff ? rd_even_ff : tcfe_pkg::RESET_CENTER;
   assign ch_b = !rd_odd_rng_ff ? '0 :
                 (rd_odd_vld_ff ? rd_odd_ff : tcfe_pkg::RESET_CENTER);

   always_comb begin
      unique case (cw.sel)
         tcfe_pkg::SEL_B0: raw = ch_a[7:0];
         tcfe_pkg::SEL_B1: raw = {ch_a[11:8], ch_b[7:4]};
         tcfe_pkg::SEL_B2: raw = {ch_b[3:0], ch_b[11:8]};
         default:          raw = ch_a[7:0];
      endcase
   end

   assign esc_need = ctrl.active && (cw.src == tcfe_pkg::SRC_DATA) && !esc_pend_ff &&
                     ((raw == cfg.flag) || (raw == cfg.escape));

   always_comb begin
      unique case (cw.src)
         tcfe_pkg::SRC_FLAG: byte_in = cfg.flag;
         tcfe_pkg::SRC_TYPE: byte_in = tcfe_pkg::FRAME_TYPE;
         tcfe_pkg::SRC_DATA: byte_in = esc_need ? cfg.escape :
                                       (esc_pend_ff ? (raw ^ cfg.mask) : raw);
         tcfe_pkg::SRC_CSUM: byte_in = csum_ff;
         default:            byte_in = cfg.flag;
      endcase
   end

   always_comb begin
      csum_in = csum_ff;
      priority if (ctrl.active && cw.csum_clr) begin
         csum_in = '0;
      end else if (ctrl.active && (cw.src == tcfe_pkg::SRC_TYPE)) begin
         csum_in = csum_ff ^ tcfe_pkg::FRAME_TYPE;
      end else if (go && (cw.src == tcfe_pkg::SRC_DATA)) begin
         csum_in = csum_ff ^ raw;
      end else begin
         csum_in = csum_ff;
      end
   end

   always_comb begin
      pair_in = pair_ff;
      priority if (ctrl.active && cw.pair_clr) begin
         pair_in = '0;
      end else if (go && cw.pair_adv && !pair_last) begin
         pair_in = pair_ff + 1'b1;
      end else begin
         pair_in = pair_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff     <= '0;
         csum_ff     <= '0;
         esc_pend_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         pair_ff     <= pair_in;
         csum_ff     <= csum_in;
         esc_pend_ff <= esc_need;
         strobe_ff   <= ctrl.active;
         last_ff     <= ctrl.active && cw.last;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign status.hold      = esc_need;
   assign status.pair_last = pair_last;
   assign out_strobe       = strobe_ff;
   assign out_byte         = byte_ff;
   assign out_last         = last_ff;

`ifndef SYNTHESIS
   // After an escape byte the masked data byte follows at once.
   a_escape_followed: assert property (@(posedge clock) disable iff (reset)
      esc_need |=> (ctrl.active && esc_pend_ff && !esc_need))
      else $error("escape byte not followed by its data byte");
   // The pair index only moves while a frame runs.
   a_pair_quiet: assert property (@(posedge clock) disable iff (reset)
      !ctrl.active |=> (pair_ff == $past(pair_ff)))
      else $error("pair index moved while idle");
   // The closing byte is the flag byte.
   a_last_is_flag: assert property (@(posedge clock) disable iff (reset)
      last_ff |-> (strobe_ff && (byte_ff == cfg.flag)))
      else $error("closing byte differs from the flag byte");
`endif

endmodule

[sim/tb_trainer_channel_frame_encoder.sv]
// Self-checking testbench for the trainer channel frame encoder.
`timescale 1ns / 1ps

module tb_trainer_channel_frame_encoder;
   import tcfe_pkg::*;

   localparam int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT;
   localparam int PAIR_COUNT    = (CHANNEL_COUNT + 1) / 2;

   // Request kinds as carried on req_type.
   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   // A register index that the block does not decode.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 4'd15;

   // Cycles to let pass after the last expected beat before the block counts as idle.
   localparam int SETTLE_CYCLES = 6;
   localparam int TAIL_CYCLES   = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 60;

   typedef enum logic [1:0] {
      OP_REQUEST,
      OP_CSR,
      OP_SETTLE
   } op_kind_t;

   // One entry of the stimulus backlog: a request, a register write or a pause.
   typedef struct {
      op_kind_t                kind;
      logic                    rtype;
      logic [INDEX_W-1:0]      chan_idx;
      logic [VALUE_W-1:0]      chan_val;
      logic [CSR_INDEX_W-1:0]  reg_idx;
      logic [VALUE_W-1:0]      reg_data;
      bit                      quiet;
   } encoder_cmd_t;

   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              closing;
   } frame_beat_t;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_type = 1'b0;
   logic [INDEX_W-1:0]      req_channel_index = '0;
   logic [VALUE_W-1:0]      req_channel_value = '0;
   logic                    rsp_strobe;
   logic [BYTE_W-1:0]       rsp_frame_byte;
   logic                    rsp_last_byte;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [VALUE_W-1:0]      csr_wdata = '0;

   trainer_channel_frame_encoder #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_channel_index(req_channel_index),
      .req_channel_value(req_channel_value),
      .rsp_strobe(rsp_strobe),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Stimulus waiting to be driven, and the frame beats the block still owes us.
   encoder_cmd_t cmd_backlog[$];
   frame_beat_t  frame_bytes_due[$];

   // The testbench's own copy of the block's state and control registers.
   logic [VALUE_W-1:0] chan_model [CHANNEL_COUNT];
   cfg_type            cfg_model;

   encoder_cmd_t cur_cmd;
   int           gap_left = 0;
   int           settle_left = 0;
   bit           settling = 1'b0;
   bit           backlog_drained = 1'b0;
   bit           fill_quiet = 1'b0;
   int           mismatch_count = 0;
   int           beat_count = 0;
   int           cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Every failure goes through here. Printing stops after a while so that a badly
   // broken block cannot flood the log, but every failure is still counted.
   task automatic flag_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   task automatic push_beat(input logic [BYTE_W-1:0] value, input logic closing);
      frame_beat_t beat;
      beat.value   = value;
      beat.closing = closing;
      frame_bytes_due.push_back(beat);
   endtask

   // Applies one accepted request to the channel model. A send request expands into
   // the full list of frame beats: flag, type byte, the stuffed pair bytes, the
   // checksum of the unstuffed bytes and the closing flag.
   task automatic predict_encoder(input encoder_cmd_t c);
      logic [BYTE_W-1:0]  csum;
      logic [BYTE_W-1:0]  data;
      logic [BYTE_W-1:0]  parts [3];
      logic [VALUE_W-1:0] lo_ch;
      logic [VALUE_W-1:0] hi_ch;
      int                 p;
      int                 j;
      if (c.rtype == REQ_SET) begin
         // Indexes past the last channel are dropped; zero means "use the center".
         if (c.chan_idx < CHANNEL_COUNT) begin
            chan_model[c.chan_idx] = (c.chan_val == '0) ? cfg_model.center : c.chan_val;
         end
      end else begin
         push_beat(cfg_model.flag, 1'b0);
         // The type byte enters the checksum but is never stuffed, even when it
         // collides with the flag or the escape byte.
         csum = FRAME_TYPE;
         push_beat(FRAME_TYPE, 1'b0);
         for (p = 0; p < PAIR_COUNT; p++) begin
            lo_ch = chan_model[2 * p];
            // With an odd channel count the last channel has no partner; it reads 0.
            hi_ch = (2 * p + 1 < CHANNEL_COUNT) ? chan_model[2 * p + 1] : '0;
            parts[0] = lo_ch[7:0];
            parts[1] = {lo_ch[11:8], hi_ch[7:4]};
            parts[2] = {hi_ch[3:0], hi_ch[11:8]};
            for (j = 0; j < 3; j++) begin
               data = parts[j];
               csum = csum ^ data;
               if (data == cfg_model.flag || data == cfg_model.escape) begin
                  push_beat(cfg_model.escape, 1'b0);
                  data = data ^ cfg_model.mask;
               end
               push_beat(data, 1'b0);
            end
         end
         push_beat(csum, 1'b0);
         push_beat(cfg_model.flag, 1'b1);
      end
   endtask

   // Driver. Everything is sampled at the rising edge, so start and busy are the
   // values that the block itself saw. The next level of start and csr_valid is
   // worked out in a variable first so that each gets one assignment per edge;
   // when the next item follows at once, start simply stays high.
   always @(posedge clock) begin
      logic next_start;
      logic next_csr_valid;
      int   n;
      next_start     = start;
      next_csr_valid = csr_valid;
      if (reset) begin
         next_start     = 1'b0;
         next_csr_valid = 1'b0;
         gap_left       = 0;
         settling       = 1'b0;
         cfg_model.center = RESET_CENTER;
         cfg_model.flag   = RESET_FLAG;
         cfg_model.escape = RESET_ESCAPE;
         cfg_model.mask   = RESET_MASK;
         for (n = 0; n < CHANNEL_COUNT; n++) begin
            chan_model[n] = RESET_CENTER;
         end
      end else begin
         // A request beat is taken on start high with busy low.
         if (start && !busy) begin
            predict_encoder(cur_cmd);
            next_start = 1'b0;
            if (!cur_cmd.quiet && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(1, 3);
            end
         end
         // A register write beat; the model follows the block's register widths.
         if (csr_valid && csr_ready) begin
            case (cur_cmd.reg_idx)
               REG_CENTER: cfg_model.center = cur_cmd.reg_data;
               REG_FLAG:   cfg_model.flag   = cur_cmd.reg_data[BYTE_W-1:0];
               REG_ESCAPE: cfg_model.escape = cur_cmd.reg_data[BYTE_W-1:0];
               REG_MASK:   cfg_model.mask   = cur_cmd.reg_data[BYTE_W-1:0];
               default: ;
            endcase
            next_csr_valid = 1'b0;
         end
         if (!next_start && !next_csr_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (settling) begin
               // Hold off until every owed beat has arrived and the block has
               // stayed idle while settle_left counts down to zero.
               if (frame_bytes_due.size() == 0 && !busy) begin
                  if (settle_left == 0) begin
                     settling = 1'b0;
                  end else begin
                     settle_left--;
                  end
               end else begin
                  settle_left = SETTLE_CYCLES;
               end
            end else if (cmd_backlog.size() != 0) begin
               if (!cmd_backlog[0].quiet && $urandom_range(0, 7) == 0) begin
                  // An idle burst right before the next item.
                  gap_left = $urandom_range(0, 2);
               end else begin
                  cur_cmd = cmd_backlog.pop_front();
                  case (cur_cmd.kind)
                     OP_REQUEST: begin
                        req_type          <= cur_cmd.rtype;
                        req_channel_index <= cur_cmd.chan_idx;
                        req_channel_value <= cur_cmd.chan_val;
                        next_start = 1'b1;
                     end
                     OP_CSR: begin
                        csr_index <= cur_cmd.reg_idx;
                        csr_wdata <= cur_cmd.reg_data;
                        next_csr_valid = 1'b1;
                     end
                     default: begin
                        settling    = 1'b1;
                        settle_left = SETTLE_CYCLES;
                     end
                  endcase
               end
            end
         end
      end
      start     <= next_start;
      csr_valid <= next_csr_valid;
      backlog_drained = (cmd_backlog.size() == 0) && !next_start && !next_csr_valid &&
                        !settling && gap_left == 0;
   end

   // Monitor. Beats cannot be held off, so every strobe cycle is one beat that is
   // compared against the oldest owed beat.
   always @(posedge clock) begin
      frame_beat_t due;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (frame_bytes_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat %0d: byte=%02h last=%b",
                                    beat_count, rsp_frame_byte, rsp_last_byte));
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== due.value) begin
               flag_mismatch($sformatf("beat %0d frame_byte: got %02h, want %02h",
                                       beat_count, rsp_frame_byte, due.value));
            end
            if (rsp_last_byte !== due.closing) begin
               flag_mismatch($sformatf("beat %0d last_byte: got %b, want %b",
                                       beat_count, rsp_last_byte, due.closing));
            end
         end
         beat_count++;
      end
   end

   task automatic queue_request(input logic rtype, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val);
      encoder_cmd_t c;
      c = '{kind: OP_REQUEST, rtype: rtype, chan_idx: idx, chan_val: val,
            reg_idx: '0, reg_data: '0, quiet: fill_quiet};
      cmd_backlog.push_back(c);
   endtask

   task automatic queue_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [VALUE_W-1:0] data);
      encoder_cmd_t c;
      c = '{kind: OP_CSR, rtype: REQ_SET, chan_idx: '0, chan_val: '0,
            reg_idx: idx, reg_data: data, quiet: fill_quiet};
      cmd_backlog.push_back(c);
   endtask

   task automatic queue_settle();
      encoder_cmd_t c;
      c = '{kind: OP_SETTLE, rtype: REQ_SET, chan_idx: '0, chan_val: '0,
            reg_idx: '0, reg_data: '0, quiet: fill_quiet};
      cmd_backlog.push_back(c);
   endtask

   initial begin
      int                 phase;
      int                 k;
      int                 pause_at;
      logic [VALUE_W-1:0] plan_center;
      logic [BYTE_W-1:0]  plan_flag;
      logic [BYTE_W-1:0]  plan_escape;
      logic [BYTE_W-1:0]  plan_mask;
      logic [VALUE_W-1:0] val;
      logic [INDEX_W-1:0] idx;

      // Directed part. First a frame straight out of reset, then channels at both
      // ends of their range, a set to zero, values whose bytes hit the flag and the
      // escape byte, and two sets past the last channel that must be dropped.
      queue_request(REQ_SEND, '0, '0);
      queue_request(REQ_SET, 4'd0, 12'hfff);
      queue_request(REQ_SET, 4'd1, 12'h001);
      queue_request(REQ_SET, 4'd2, 12'h000);
      queue_request(REQ_SET, 4'd3, 12'he07);
      queue_request(REQ_SET, 4'd4, 12'h07e);
      queue_request(REQ_SET, 4'd6, 12'h07d);
      queue_request(REQ_SET, 4'd8, 12'h123);
      queue_request(REQ_SET, 4'd15, 12'hfff);
      queue_request(REQ_SEND, '0, '0);

      // Center at its low extreme and a full mask, with the flag on the type byte and an escape
      // byte of zero; a write to an undecoded index must change nothing.
      queue_settle();
      queue_csr(REG_CENTER, 12'h000);
      queue_csr(REG_FLAG, 12'hf80);
      queue_csr(REG_ESCAPE, 12'h000);
      queue_csr(REG_MASK, 12'h0ff);
      queue_csr(REG_UNUSED, 12'hfff);
      queue_request(REQ_SET, 4'd5, 12'h000);
      queue_request(REQ_SET, 4'd7, 12'h800);
      queue_request(REQ_SET, 4'd1, 12'h080);
      queue_request(REQ_SEND, '0, '0);

      // High extremes but a zero mask; flag equals escape. Only later sets see the new center.
      queue_settle();
      queue_csr(REG_CENTER, 12'hfff);
      queue_csr(REG_FLAG, 12'h0ff);
      queue_csr(REG_ESCAPE, 12'h0ff);
      queue_csr(REG_MASK, 12'hf00);
      queue_request(REQ_SET, 4'd6, 12'h000);
      queue_request(REQ_SET, 4'd0, 12'hfff);
      queue_request(REQ_SEND, '0, '0);

      // Back to the reset settings.
      queue_settle();
      queue_csr(REG_CENTER, RESET_CENTER);
      queue_csr(REG_FLAG, {4'h0, RESET_FLAG});
      queue_csr(REG_ESCAPE, {4'h0, RESET_ESCAPE});
      queue_csr(REG_MASK, {4'h0, RESET_MASK});
      queue_request(REQ_SET, 4'd2, 12'h000);
      queue_request(REQ_SEND, '0, '0);

      // Random part in phases. Each phase starts from a fresh register setting and
      // pauses once in the middle until every owed beat is in. The last phase runs
      // without idle bursts so that back-to-back requests get exercised too.
      for (phase = 0; phase < 8; phase++) begin
         fill_quiet = (phase == 7);
         case ($urandom_range(0, 3))
            0: plan_center = '0;
            1: plan_center = '1;
            default: plan_center = 12'($urandom_range(0, 4095));
         endcase
         case ($urandom_range(0, 5))
            0: plan_flag = 8'h00;
            1: plan_flag = 8'hff;
            2: plan_flag = FRAME_TYPE;
            3: plan_flag = plan_center[7:0];
            default: plan_flag = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 5))
            0: plan_escape = plan_flag;
            1: plan_escape = 8'h00;
            2: plan_escape = 8'hff;
            3: plan_escape = FRAME_TYPE;
            default: plan_escape = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 3))
            0: plan_mask = 8'h00;
            1: plan_mask = 8'hff;
            default: plan_mask = 8'($urandom_range(0, 255));
         endcase
         queue_settle();
         // The upper nibble of an 8-bit register write is random and must be dropped.
         queue_csr(REG_CENTER, plan_center);
         queue_csr(REG_FLAG, {4'($urandom_range(0, 15)), plan_flag});
         queue_csr(REG_ESCAPE, {4'($urandom_range(0, 15)), plan_escape});
         queue_csr(REG_MASK, {4'($urandom_range(0, 15)), plan_mask});
         if ($urandom_range(0, 1) == 0) begin
            queue_csr(4'($urandom_range(4, 15)), 12'($urandom_range(0, 4095)));
         end

         pause_at = $urandom_range(5, 35);
         for (k = 0; k < 40; k++) begin
            if (k == pause_at) begin
               queue_settle();
            end
            if ($urandom_range(0, 99) < 35) begin
               queue_request(REQ_SEND, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            end else begin
               idx = ($urandom_range(0, 99) < 12) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(0, CHANNEL_COUNT - 1));
               // Many values are shaped so that a packed byte lands on the flag or
               // the escape byte of this phase, which forces stuffing.
               case ($urandom_range(0, 9))
                  0: val = '0;
                  1: val = '1;
                  2: val = {4'($urandom_range(0, 15)), plan_flag};
                  3: val = {4'($urandom_range(0, 15)), plan_escape};
                  4: val = {plan_escape[3:0], 4'($urandom_range(0, 15)), plan_escape[7:4]};
                  5: val = {plan_flag[3:0], 4'($urandom_range(0, 15)), plan_flag[7:4]};
                  default: val = 12'($urandom_range(0, 4095));
               endcase
               queue_request(REQ_SET, idx, val);
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!(backlog_drained && frame_bytes_due.size() == 0 && !busy) &&
             cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_trainer_channel_frame_encoder: FAIL");
      end else begin
         // Any stray beat in this window is caught by the monitor.
         repeat (TAIL_CYCLES) @(posedge clock);
         if (frame_bytes_due.size() != 0) begin
            flag_mismatch($sformatf("%0d expected beats never arrived",
                                    frame_bytes_due.size()));
         end
         if (mismatch_count == 0) begin
            $display("tb_trainer_channel_frame_encoder: PASS");
         end else begin
            $display("tb_trainer_channel_frame_encoder: FAIL");
         end
      end
      $finish;
   end

endmodule

[sim.f]
sv/tcfe_pkg.sv
sv/tcfe_seq.sv
sv/tcfe_dp.sv
sv/trainer_channel_frame_encoder.sv
sim/tb_trainer_channel_frame_encoder.sv
